/* src/ps2sa_pkg.sv */
`timescale 1ns / 1ps

package ps2sa_pkg;

    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [7:0] SC_RELEASE    = 8'h80;
    localparam logic [6:0] SC_CODE_MASK  = 7'h7F;
    localparam logic [6:0] SC_CTRL       = 7'h1D;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_ENTER      = 7'h1C;
    localparam logic [6:0] SC_MAP_SIZE   = 7'd58;

    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_LEFT       = 7'h4B;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_HOME       = 7'h47;
    localparam logic [6:0] SC_END        = 7'h4F;
    localparam logic [6:0] SC_PGUP       = 7'h49;
    localparam logic [6:0] SC_PGDN       = 7'h51;
    localparam logic [6:0] SC_DELETE     = 7'h53;

    localparam logic [6:0] CH_SHIFT_ENTER = 7'h0F;
    localparam logic [6:0] CH_CTRL_MASK   = 7'h1F;
    localparam logic [6:0] CH_UP          = 7'h10;
    localparam logic [6:0] CH_DOWN        = 7'h0E;
    localparam logic [6:0] CH_LEFT        = 7'h02;
    localparam logic [6:0] CH_RIGHT       = 7'h06;
    localparam logic [6:0] CH_HOME        = 7'h01;
    localparam logic [6:0] CH_END         = 7'h05;
    localparam logic [6:0] CH_PGUP        = 7'h19;
    localparam logic [6:0] CH_PGDN        = 7'h1A;
    localparam logic [6:0] CH_DELETE      = 7'h7F;
    localparam logic [6:0] CH_NONE        = 7'h00;

    localparam logic REQ_SCANCODE = 1'b0;
    localparam logic REQ_READ     = 1'b1;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic ext;
    } flags_t;

    typedef struct packed {
        logic       push;
        logic [6:0] push_char;
        logic       shift_we;
        logic       shift_val;
        logic       ctrl_we;
        logic       ctrl_val;
        logic       ext_next;
    } dec_t;

    function automatic logic [6:0] plain_map(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'd1:  ch = 7'h1B; 6'd2:  ch = 7'h31; 6'd3:  ch = 7'h32; 6'd4:  ch = 7'h33;
            6'd5:  ch = 7'h34; 6'd6:  ch = 7'h35; 6'd7:  ch = 7'h36; 6'd8:  ch = 7'h37;
            6'd9:  ch = 7'h38; 6'd10: ch = 7'h39; 6'd11: ch = 7'h30; 6'd12: ch = 7'h2D;
            6'd13: ch = 7'h3D; 6'd14: ch = 7'h08; 6'd15: ch = 7'h09; 6'd16: ch = 7'h71;
            6'd17: ch = 7'h77; 6'd18: ch = 7'h65; 6'd19: ch = 7'h72; 6'd20: ch = 7'h74;
            6'd21: ch = 7'h79; 6'd22: ch = 7'h75; 6'd23: ch = 7'h69; 6'd24: ch = 7'h6F;
            6'd25: ch = 7'h70; 6'd26: ch = 7'h5B; 6'd27: ch = 7'h5D; 6'd28: ch = 7'h0A;
            6'd30: ch = 7'h61; 6'd31: ch = 7'h73; 6'd32: ch = 7'h64; 6'd33: ch = 7'h66;
            6'd34: ch = 7'h67; 6'd35: ch = 7'h68; 6'd36: ch = 7'h6A; 6'd37: ch = 7'h6B;
            6'd38: ch = 7'h6C; 6'd39: ch = 7'h3B; 6'd40: ch = 7'h27; 6'd41: ch = 7'h60;
            6'd43: ch = 7'h5C; 6'd44: ch = 7'h7A; 6'd45: ch = 7'h78; 6'd46: ch = 7'h63;
            6'd47: ch = 7'h76; 6'd48: ch = 7'h62; 6'd49: ch = 7'h6E; 6'd50: ch = 7'h6D;
            6'd51: ch = 7'h2C; 6'd52: ch = 7'h2E; 6'd53: ch = 7'h2F; 6'd55: ch = 7'h2A;
            6'd57: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shifted_map(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'd1:  ch = 7'h1B; 6'd2:  ch = 7'h21; 6'd3:  ch = 7'h40; 6'd4:  ch = 7'h23;
            6'd5:  ch = 7'h24; 6'd6:  ch = 7'h25; 6'd7:  ch = 7'h5E; 6'd8:  ch = 7'h26;
            6'd9:  ch = 7'h2A; 6'd10: ch = 7'h28; 6'd11: ch = 7'h29; 6'd12: ch = 7'h5F;
            6'd13: ch = 7'h2B; 6'd14: ch = 7'h08; 6'd15: ch = 7'h09; 6'd16: ch = 7'h51;
            6'd17: ch = 7'h57; 6'd18: ch = 7'h45; 6'd19: ch = 7'h52; 6'd20: ch = 7'h54;
            6'd21: ch = 7'h59; 6'd22: ch = 7'h55; 6'd23: ch = 7'h49; 6'd24: ch = 7'h4F;
            6'd25: ch = 7'h50; 6'd26: ch = 7'h7B; 6'd27: ch = 7'h7D; 6'd28: ch = 7'h0A;
            6'd30: ch = 7'h41; 6'd31: ch = 7'h53; 6'd32: ch = 7'h44; 6'd33: ch = 7'h46;
            6'd34: ch = 7'h47; 6'd35: ch = 7'h48; 6'd36: ch = 7'h4A; 6'd37: ch = 7'h4B;
            6'd38: ch = 7'h4C; 6'd39: ch = 7'h3A; 6'd40: ch = 7'h22; 6'd41: ch = 7'h7E;
            6'd43: ch = 7'h7C; 6'd44: ch = 7'h5A; 6'd45: ch = 7'h58; 6'd46: ch = 7'h43;
            6'd47: ch = 7'h56; 6'd48: ch = 7'h42; 6'd49: ch = 7'h4E; 6'd50: ch = 7'h4D;
            6'd51: ch = 7'h3C; 6'd52: ch = 7'h3E; 6'd53: ch = 7'h3F; 6'd55: ch = 7'h2A;
            6'd57: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] ext_map(input logic [6:0] code);
        logic [6:0] ch;
        unique case (code)
            SC_UP:     ch = CH_UP;
            SC_DOWN:   ch = CH_DOWN;
            SC_LEFT:   ch = CH_LEFT;
            SC_RIGHT:  ch = CH_RIGHT;
            SC_HOME:   ch = CH_HOME;
            SC_END:    ch = CH_END;
            SC_PGUP:   ch = CH_PGUP;
            SC_PGDN:   ch = CH_PGDN;
            SC_DELETE: ch = CH_DELETE;
            default:   ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

/* src/ps2sa_decode.sv */
`timescale 1ns / 1ps

module ps2sa_decode (
    input  logic [7:0]        scan_byte,
    input  ps2sa_pkg::flags_t flags,
    output ps2sa_pkg::dec_t   dec
);

    logic       release_bit;
    logic [6:0] code;
    logic [6:0] map_ch;
    logic [6:0] ext_ch;
    logic       is_letter;

    assign release_bit = (scan_byte & ps2sa_pkg::SC_RELEASE) != 8'h00;
    assign code        = scan_byte[6:0] & ps2sa_pkg::SC_CODE_MASK;
    assign map_ch      = flags.shift ? ps2sa_pkg::shifted_map(code[5:0])
                                     : ps2sa_pkg::plain_map(code[5:0]);
    assign ext_ch      = ps2sa_pkg::ext_map(code);
    assign is_letter   = (map_ch >= 7'h61 && map_ch <= 7'h7A) ||
                         (map_ch >= 7'h41 && map_ch <= 7'h5A);

    always_comb begin
        dec           = '0;
        dec.push_char = ps2sa_pkg::CH_NONE;
        if (scan_byte == ps2sa_pkg::SC_EXT_PREFIX) begin
            dec.ext_next = 1'b1;
        end else if (flags.ext) begin
            if (code == ps2sa_pkg::SC_CTRL) begin
                dec.ctrl_we  = 1'b1;
                dec.ctrl_val = !release_bit;
            end else if (!release_bit) begin
                dec.push_char = ext_ch;
                dec.push      = ext_ch != ps2sa_pkg::CH_NONE;
            end
        end else if (code == ps2sa_pkg::SC_LSHIFT || code == ps2sa_pkg::SC_RSHIFT) begin
            dec.shift_we  = 1'b1;
            dec.shift_val = !release_bit;
        end else if (code == ps2sa_pkg::SC_CTRL) begin
            dec.ctrl_we  = 1'b1;
            dec.ctrl_val = !release_bit;
        end else if (!release_bit) begin
            if (code == ps2sa_pkg::SC_ENTER && flags.shift) begin
                dec.push      = 1'b1;
                dec.push_char = ps2sa_pkg::CH_SHIFT_ENTER;
            end else if (code < ps2sa_pkg::SC_MAP_SIZE) begin
                dec.push_char = (flags.ctrl && is_letter) ?
                                (map_ch & ps2sa_pkg::CH_CTRL_MASK) : map_ch;
                dec.push      = map_ch != ps2sa_pkg::CH_NONE;
            end
        end
    end

endmodule

/* src/ps2_set1_scancode_to_ascii_fifo_top.sv */
`timescale 1ns / 1ps
// Channel | Dir | tdata                 | tuser
// s_      | in  | [7:0] scan_byte       | [0] req_type (0 scancode, 1 read)
// m_      | out | [6:0] char_code, [7]0 | [0] has_char
//
// One request per cycle while the input register is not held by a waiting read.
// A scancode updates modifiers and pushes into the ring as it leaves the input register, no result.
// A read's result is presented at the edge it leaves the input register, with data
// from the registered ring read port.
// aresetn (sync, active low) empties the ring and clears modifiers.
// A read waits in the input register only while the output holds an untaken result.

module ps2_set1_scancode_to_ascii_fifo_top #(
    parameter int RING_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    input  logic       s_tuser,   // [0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tuser    // [0] has_char
);

    localparam int              PTR_W    = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic             in_valid_reg;
    logic             in_type_reg;
    logic [7:0]       in_byte_reg;
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic             shift_reg, ctrl_reg, ext_reg;
    logic             m_valid_reg;
    logic             has_char_reg;
    logic [6:0]       rd_data_reg;
    logic [6:0]       ring_mem [RING_DEPTH];

    ps2sa_pkg::flags_t flags;
    ps2sa_pkg::dec_t   dec;
    logic              out_free, is_read, adv, is_scan;
    logic              empty, full, push_do, pop_do, read_do;
    logic [PTR_W-1:0]  wptr_inc, rptr_inc;

    assign flags = '{shift: shift_reg, ctrl: ctrl_reg, ext: ext_reg};

    ps2sa_decode u_decode (
        .scan_byte (in_byte_reg),
        .flags     (flags),
        .dec       (dec)
    );

    assign wptr_inc = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
    assign empty    = wptr_reg == rptr_reg;
    assign full     = wptr_inc == rptr_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign is_read  = in_valid_reg && (in_type_reg == ps2sa_pkg::REQ_READ);
    assign is_scan  = in_valid_reg && (in_type_reg == ps2sa_pkg::REQ_SCANCODE);
    assign read_do  = is_read && out_free;
    assign adv      = is_scan || read_do;
    assign push_do  = is_scan && dec.push && !full;
    assign pop_do   = read_do && !empty;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            ext_reg   <= 1'b0;
        end else begin
            if (push_do) begin
                wptr_reg <= wptr_inc;
            end
            if (pop_do) begin
                rptr_reg <= rptr_inc;
            end
            if (is_scan) begin
                ext_reg <= dec.ext_next;
                if (dec.shift_we) begin
                    shift_reg <= dec.shift_val;
                end
                if (dec.ctrl_we) begin
                    ctrl_reg <= dec.ctrl_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_do) begin
            ring_mem[wptr_reg] <= dec.push_char;
        end
        if (pop_do) begin
            rd_data_reg <= ring_mem[rptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= read_do;
        end
        if (read_do) begin
            has_char_reg <= !empty;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = has_char_reg;
    assign m_tdata  = {1'b0, has_char_reg ? rd_data_reg : ps2sa_pkg::CH_NONE};

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wptr_reg <= PTR_LAST && rptr_reg <= PTR_LAST)
        else $error("ring pointer out of range");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_do |=> m_tvalid && m_tuser)
        else $error("pop did not present a character");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (read_do && empty) |=> m_tvalid && !m_tuser && m_tdata == 8'h00)
        else $error("empty read result wrong");

    a_prefix_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_scan && in_byte_reg == ps2sa_pkg::SC_EXT_PREFIX) |=> ext_reg)
        else $error("extended prefix not recorded");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        push_do |=> wptr_reg != rptr_reg)
        else $error("push left ring looking empty");

endmodule

/* bench/ps2_set1_scancode_to_ascii_fifo_top_tb.sv */
`timescale 1ns / 1ps

module ps2_set1_scancode_to_ascii_fifo_top_tb;

    localparam int RING_DEPTH = 256;
    localparam int RANDOM_REQS = 1000;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_byte;
    } kbd_req_t;

    typedef struct packed {
        logic       has_char;
        logic [6:0] char_code;
    } read_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = ps2sa_pkg::REQ_SCANCODE;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;

    kbd_req_t     pending_reqs[$];
    read_result_t expected_reads[$];
    logic [6:0]   typed_chars[$];
    logic [6:0]   plain_chars[58];
    logic [6:0]   shifted_chars[58];
    logic [6:0]   nav_codes[9];
    logic         shift_held = 1'b0;
    logic         ctrl_held = 1'b0;
    logic         ext_pending = 1'b0;
    logic         s_taken = 1'b0;
    int           cycle_cnt = 0;
    int           err_cnt = 0;

    ps2_set1_scancode_to_ascii_fifo_top #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic quiet_window();
        return cycle_cnt >= 1000 && cycle_cnt < 2000;
    endfunction

    task automatic translate_scancode(input logic [7:0] sc);
        logic       released;
        logic [6:0] code;
        logic [6:0] ch;
        released = sc[7];
        code = sc[6:0];
        ch = ps2sa_pkg::CH_NONE;
        if (sc == ps2sa_pkg::SC_EXT_PREFIX) begin
            ext_pending = 1'b1;
            return;
        end
        if (ext_pending) begin
            ext_pending = 1'b0;
            if (code == ps2sa_pkg::SC_CTRL) begin
                ctrl_held = !released;
            end else if (!released) begin
                case (code)
                    ps2sa_pkg::SC_UP:     ch = ps2sa_pkg::CH_UP;
                    ps2sa_pkg::SC_DOWN:   ch = ps2sa_pkg::CH_DOWN;
                    ps2sa_pkg::SC_LEFT:   ch = ps2sa_pkg::CH_LEFT;
                    ps2sa_pkg::SC_RIGHT:  ch = ps2sa_pkg::CH_RIGHT;
                    ps2sa_pkg::SC_HOME:   ch = ps2sa_pkg::CH_HOME;
                    ps2sa_pkg::SC_END:    ch = ps2sa_pkg::CH_END;
                    ps2sa_pkg::SC_PGUP:   ch = ps2sa_pkg::CH_PGUP;
                    ps2sa_pkg::SC_PGDN:   ch = ps2sa_pkg::CH_PGDN;
                    ps2sa_pkg::SC_DELETE: ch = ps2sa_pkg::CH_DELETE;
                    default:              ch = ps2sa_pkg::CH_NONE;
                endcase
            end
        end else if (code == ps2sa_pkg::SC_LSHIFT || code == ps2sa_pkg::SC_RSHIFT) begin
            shift_held = !released;
        end else if (code == ps2sa_pkg::SC_CTRL) begin
            ctrl_held = !released;
        end else if (!released) begin
            if (code == ps2sa_pkg::SC_ENTER && shift_held) begin
                ch = ps2sa_pkg::CH_SHIFT_ENTER;
            end else if (code < ps2sa_pkg::SC_MAP_SIZE) begin
                ch = shift_held ? shifted_chars[code] : plain_chars[code];
                if (ctrl_held && ((ch >= 7'h61 && ch <= 7'h7A) ||
                                  (ch >= 7'h41 && ch <= 7'h5A)))
                    ch = ch & ps2sa_pkg::CH_CTRL_MASK;
            end
        end
        // full ring drops the character
        if (ch != ps2sa_pkg::CH_NONE && typed_chars.size() < RING_DEPTH - 1)
            typed_chars.push_back(ch);
    endtask

    task automatic read_char_request();
        read_result_t r;
        if (typed_chars.size() == 0) begin
            r = '{1'b0, ps2sa_pkg::CH_NONE};
        end else begin
            r = '{1'b1, typed_chars.pop_front()};
        end
        expected_reads.push_back(r);
    endtask

    task automatic add_scan(input logic [7:0] b);
        pending_reqs.push_back('{ps2sa_pkg::REQ_SCANCODE, b});
    endtask

    task automatic add_read();
        pending_reqs.push_back('{ps2sa_pkg::REQ_READ, 8'($urandom_range(0, 255))});
    endtask

    task automatic add_tap(input logic [6:0] code);
        add_scan({1'b0, code});
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, code});
    endtask

    function automatic logic [6:0] random_key();
        return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 57));
    endfunction

    // driver
    always @(negedge aclk) begin
        kbd_req_t nxt;
        if (!s_tvalid || s_taken) begin
            if (aresetn && pending_reqs.size() != 0 &&
                (quiet_window() || $urandom_range(0, 99) >= 27)) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.req_type;
                s_tdata  <= nxt.scan_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= quiet_window() || ($urandom_range(0, 99) >= 27);
    end

    // monitor
    always @(posedge aclk) begin
        read_result_t exp_r;
        s_taken = 1'b0;
        if (aresetn) begin
            cycle_cnt = cycle_cnt + 1;
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                if (s_tuser == ps2sa_pkg::REQ_READ)
                    read_char_request();
                else
                    translate_scancode(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: unexpected result has_char=%0b char=%02h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_r = expected_reads.pop_front();
                    if (m_tuser !== exp_r.has_char) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: has_char expected %0b actual %0b",
                                 $time, exp_r.has_char, m_tuser);
                    end
                    if (m_tdata !== {1'b0, exp_r.char_code}) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: char_code expected %02h actual %02h",
                                 $time, {1'b0, exp_r.char_code}, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int         kind;
        int         n;
        int         base;
        logic       burst_done;
        logic       via_ext;
        logic [6:0] mod;

        plain_chars = '{
            7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
            7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
            7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
            7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
            7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
        };
        shifted_chars = '{
            7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
            7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
            7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
            7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
            7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
        };
        nav_codes = '{ps2sa_pkg::SC_UP, ps2sa_pkg::SC_DOWN, ps2sa_pkg::SC_LEFT,
                      ps2sa_pkg::SC_RIGHT, ps2sa_pkg::SC_HOME, ps2sa_pkg::SC_END,
                      ps2sa_pkg::SC_PGUP, ps2sa_pkg::SC_PGDN, ps2sa_pkg::SC_DELETE};

        // directed: empty read, letters, shift, shift+enter, ctrl, extended keys
        add_read();
        add_scan(8'h00);
        add_tap(7'h1E);
        add_scan({1'b0, ps2sa_pkg::SC_LSHIFT});
        add_scan(8'h1E);
        add_scan({1'b0, ps2sa_pkg::SC_ENTER});
        add_scan(8'h02);
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_LSHIFT});
        add_scan({1'b0, ps2sa_pkg::SC_CTRL});
        add_scan(8'h2E);
        add_scan(8'h02);
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_CTRL});
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan({1'b0, ps2sa_pkg::SC_UP});
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan({1'b0, ps2sa_pkg::SC_DELETE});
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_UP});
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan({1'b0, ps2sa_pkg::SC_CTRL});
        add_scan(8'h1E);
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_CTRL});
        add_scan({1'b0, ps2sa_pkg::SC_RSHIFT});
        add_scan(8'h39);
        add_scan(8'h3A);
        add_scan(8'hFF);
        add_scan(ps2sa_pkg::SC_EXT_PREFIX);
        add_scan({1'b0, ps2sa_pkg::SC_LSHIFT});
        add_scan(8'h1E);
        add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_RSHIFT});
        repeat (14) add_read();

        base = pending_reqs.size();
        burst_done = 1'b0;
        while (pending_reqs.size() < base + RANDOM_REQS) begin
            if (!burst_done && pending_reqs.size() > base + 500) begin
                // overfill the ring, then drain it past empty
                burst_done = 1'b1;
                repeat (270) add_scan(8'($urandom_range(16, 25)));
                repeat (262) add_read();
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                add_tap(random_key());
            end else if (kind < 50) begin
                mod = $urandom_range(0, 1) ? ps2sa_pkg::SC_LSHIFT : ps2sa_pkg::SC_RSHIFT;
                add_scan({1'b0, mod});
                n = $urandom_range(1, 3);
                repeat (n) add_tap(random_key());
                if ($urandom_range(0, 1)) add_tap(ps2sa_pkg::SC_ENTER);
                add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, mod});
            end else if (kind < 60) begin
                via_ext = 1'($urandom_range(0, 1));
                if (via_ext) add_scan(ps2sa_pkg::SC_EXT_PREFIX);
                add_scan({1'b0, ps2sa_pkg::SC_CTRL});
                n = $urandom_range(1, 2);
                repeat (n) add_tap(random_key());
                if (via_ext) add_scan(ps2sa_pkg::SC_EXT_PREFIX);
                add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, ps2sa_pkg::SC_CTRL});
            end else if (kind < 70) begin
                mod = $urandom_range(0, 3) == 0 ? random_key()
                                                : nav_codes[$urandom_range(0, 8)];
                add_scan(ps2sa_pkg::SC_EXT_PREFIX);
                add_scan({1'b0, mod});
                add_scan(ps2sa_pkg::SC_EXT_PREFIX);
                add_scan(ps2sa_pkg::SC_RELEASE | {1'b0, mod});
            end else if (kind < 90) begin
                n = $urandom_range(1, 4);
                repeat (n) add_read();
            end else begin
                add_scan(8'($urandom_range(0, 255)));
            end
        end
        repeat (300) add_read();

        wait (aresetn);
        while (pending_reqs.size() != 0 || s_tvalid || expected_reads.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
